@@ sv/vts_pkg.sv @@
// Package for the virtual runtime run queue: sizes, codes, entry and command types.
// Used by the interfaces, the cell, the cell row and the top level.
package vts_pkg;

    localparam int QUEUE_DEPTH  = 32;
    localparam int TASK_ID_BITS = 8;

    localparam int ID_W        = TASK_ID_BITS;
    localparam int VR_W        = 32;
    localparam int SLICE_W     = 16;
    localparam int TICK_W      = 32;
    localparam int OP_W        = 2;
    localparam int FIELD_ID_W  = 8;
    localparam int CNT_FIELD_W = 6;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int POS_W       = $clog2(QUEUE_DEPTH);

    localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
    localparam logic [OP_W-1:0] OP_ENQUEUE  = 2'd1;
    localparam logic [OP_W-1:0] OP_SCHEDULE = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]    task_id;
        logic [VR_W-1:0]    vruntime;
        logic [SLICE_W-1:0] slice;
    } vts_entry_t;

    typedef enum logic [1:0] {
        SEL_HOLD,
        SEL_LEFT,
        SEL_RIGHT,
        SEL_KEY
    } vts_sel_t;

    typedef struct packed {
        logic             push;
        logic             pop;
        logic [POS_W-1:0] pos;
    } vts_row_cmd_t;

endpackage

@@ sv/vts_ifs.sv @@
// Handshake interfaces for the request, response and configuration channels.
// Depends on vts_pkg for the field widths.
interface vts_req_if import vts_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       op;
    logic [FIELD_ID_W-1:0] task_id;
    logic [VR_W-1:0]       task_vruntime;
    logic [SLICE_W-1:0]    task_slice;
    logic                  still_running;

    modport source (output valid, op, task_id, task_vruntime, task_slice, still_running,
                    input ready);
    modport sink (input valid, op, task_id, task_vruntime, task_slice, still_running,
                  output ready);
endinterface

interface vts_rsp_if import vts_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [FIELD_ID_W-1:0]  next_task;
    logic                   switched;
    logic [CNT_FIELD_W-1:0] queued_count;
    logic                   queue_full_error;

    modport source (output valid, next_task, switched, queued_count, queue_full_error,
                    input ready);
    modport sink (input valid, next_task, switched, queued_count, queue_full_error,
                  output ready);
endinterface

interface vts_cfg_if import vts_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [FIELD_ID_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

@@ sv/vts_cell.sv @@
// One run queue slot: holds an entry, loads from a neighbour or the key, flags insert point.
// Depends on vts_pkg.
module vts_cell import vts_pkg::*;
(
    input  logic            clk,
    input  vts_sel_t        sel,
    input  vts_entry_t      left,
    input  vts_entry_t      right,
    input  vts_entry_t      key,
    input  logic [ID_W-1:0] idle_id,
    output vts_entry_t      entry,
    output logic            stop
);

    vts_entry_t entry_reg;
    vts_entry_t entry_next;

    always_comb
    begin
        case (sel)
            SEL_LEFT:  entry_next = left;
            SEL_RIGHT: entry_next = right;
            SEL_KEY:   entry_next = key;
            default:   entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // The new entry goes in front of the idle task or of any entry not smaller than it.
    assign stop  = (entry_reg.task_id == idle_id) || (key.vruntime <= entry_reg.vruntime);
    assign entry = entry_reg;

endmodule

@@ sv/vts_row.sv @@
// Row of queue cells that shifts left on a pop and opens a gap on a push.
// Depends on vts_pkg and vts_cell.
module vts_row import vts_pkg::*;
(
    input  logic                   clk,
    input  vts_row_cmd_t           cmd,
    input  vts_entry_t             key,
    input  logic [ID_W-1:0]        idle_id,
    output vts_entry_t             head,
    output logic [QUEUE_DEPTH-1:0] stop_vec
);

    vts_entry_t cell_entry [QUEUE_DEPTH];

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        vts_sel_t   sel;
        vts_entry_t left;
        vts_entry_t right;

        always_comb
        begin
            if (cmd.pop)
            begin
                sel = SEL_RIGHT;
            end
            else if (cmd.push && (POS_W'(i) == cmd.pos))
            begin
                sel = SEL_KEY;
            end
            else if (cmd.push && (POS_W'(i) > cmd.pos))
            begin
                sel = SEL_LEFT;
            end
            else
            begin
                sel = SEL_HOLD;
            end
        end

        if (i == 0)
        begin : g_first
            assign left = key;
        end
        else
        begin : g_inner_left
            assign left = cell_entry[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right = cell_entry[i];
        end
        else
        begin : g_inner_right
            assign right = cell_entry[i+1];
        end

        vts_cell u_cell (
            .clk     (clk),
            .sel     (sel),
            .left    (left),
            .right   (right),
            .key     (key),
            .idle_id (idle_id),
            .entry   (cell_entry[i]),
            .stop    (stop_vec[i])
        );
    end

    assign head = cell_entry[0];

endmodule

@@ sv/vruntime_timeslice_scheduler_top.sv @@
// Top level of the virtual runtime run queue scheduler: control sequencer and task state.
// Depends on vts_pkg, the interfaces in vts_ifs and vts_row.
//
//   Channel | Direction | Beat contents
//   req     | in        | op, task_id, task_vruntime, task_slice, still_running
//   rsp     | out       | next_task, switched, queued_count, queue_full_error
//   cfg     | in        | data (idle task number)
//
// A tick or an unused op goes straight to the done state. An enqueue to a queue that is not full
// searches the insert point one cell per cycle along the row; a schedule that reinserts the
// outgoing task makes the same search, after its pop.
// Reset clears the control state and the task state; the row needs no clearing.
// A new request is taken while the previous response still waits in its output register.
module vruntime_timeslice_scheduler_top import vts_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    vts_req_if.sink  req,
    vts_rsp_if.source rsp,
    vts_cfg_if.sink  cfg
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t               state_reg,       state_next;
    logic [CNT_W-1:0]     len_reg,         len_next;
    logic [ID_W-1:0]      idle_reg,        idle_next;
    logic [ID_W-1:0]      run_task_reg,    run_task_next;
    logic [VR_W-1:0]      run_vr_reg,      run_vr_next;
    logic [SLICE_W-1:0]   run_slice_reg,   run_slice_next;
    logic [TICK_W-1:0]    tick_reg,        tick_next;
    logic [TICK_W-1:0]    switch_tick_reg, switch_tick_next;
    vts_entry_t           key_reg,         key_next;
    logic [POS_W-1:0]     pos_reg,         pos_next;
    logic                 switched_reg,    switched_next;
    logic                 full_reg,        full_next;
    logic                 rsp_valid_reg,   rsp_valid_next;
    logic [ID_W-1:0]      rsp_task_reg,    rsp_task_next;
    logic                 rsp_sw_reg,      rsp_sw_next;
    logic [CNT_W-1:0]     rsp_cnt_reg,     rsp_cnt_next;
    logic                 rsp_full_reg,    rsp_full_next;

    vts_row_cmd_t           row_cmd;
    vts_entry_t             head;
    logic [QUEUE_DEPTH-1:0] stop_vec;

    logic [TICK_W-1:0] used;
    logic [VR_W:0]     charge_sum;
    logic [VR_W-1:0]   charged_vr;
    logic              is_idle;
    logic              do_switch;
    logic [ID_W-1:0]   in_id;
    logic              at_end;

    assign in_id      = ID_W'(req.task_id);
    assign used       = tick_reg - switch_tick_reg;
    assign is_idle    = (run_task_reg == idle_reg);
    assign charge_sum = {1'b0, run_vr_reg} + {1'b0, VR_W'(used)};
    assign charged_vr = charge_sum[VR_W] ? {VR_W{1'b1}} : charge_sum[VR_W-1:0];
    assign do_switch  = (len_reg != '0)
                        && (is_idle || (used >= TICK_W'(run_slice_reg)) || !req.still_running);
    assign at_end     = (CNT_W'(pos_reg) == len_reg);

    always_comb
    begin
        state_next       = state_reg;
        len_next         = len_reg;
        idle_next        = idle_reg;
        run_task_next    = run_task_reg;
        run_vr_next      = run_vr_reg;
        run_slice_next   = run_slice_reg;
        tick_next        = tick_reg;
        switch_tick_next = switch_tick_reg;
        key_next         = key_reg;
        pos_next         = pos_reg;
        switched_next    = switched_reg;
        full_next        = full_reg;
        rsp_valid_next   = rsp_valid_reg;
        rsp_task_next    = rsp_task_reg;
        rsp_sw_next      = rsp_sw_reg;
        rsp_cnt_next     = rsp_cnt_reg;
        rsp_full_next    = rsp_full_reg;
        row_cmd.push     = 1'b0;
        row_cmd.pop      = 1'b0;
        row_cmd.pos      = pos_reg;

        if (cfg.valid)
        begin
            idle_next = ID_W'(cfg.data);
        end

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    switched_next = 1'b0;
                    full_next     = 1'b0;
                    state_next    = S_DONE;
                    case (req.op)
                        OP_TICK:
                        begin
                            tick_next = tick_reg + 1'b1;
                        end
                        OP_ENQUEUE:
                        begin
                            if (len_reg >= CNT_W'(QUEUE_DEPTH))
                            begin
                                full_next = 1'b1;
                            end
                            else
                            begin
                                key_next.task_id  = in_id;
                                key_next.vruntime = req.task_vruntime;
                                key_next.slice    = req.task_slice;
                                pos_next   = (in_id == idle_reg) ? POS_W'(len_reg) : '0;
                                state_next = S_SCAN;
                            end
                        end
                        OP_SCHEDULE:
                        begin
                            if (do_switch)
                            begin
                                row_cmd.pop      = 1'b1;
                                len_next         = len_reg - 1'b1;
                                run_task_next    = head.task_id;
                                run_vr_next      = head.vruntime;
                                run_slice_next   = head.slice;
                                switch_tick_next = tick_reg;
                                switched_next    = 1'b1;
                                key_next.task_id  = run_task_reg;
                                key_next.vruntime = is_idle ? run_vr_reg : charged_vr;
                                key_next.slice    = run_slice_reg;
                                if (req.still_running)
                                begin
                                    pos_next   = is_idle ? POS_W'(len_reg - 1'b1) : '0;
                                    state_next = S_SCAN;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (at_end || stop_vec[pos_reg])
                begin
                    row_cmd.push = 1'b1;
                    len_next     = len_reg + 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_task_next  = run_task_reg;
                    rsp_sw_next    = switched_reg;
                    rsp_cnt_next   = len_reg;
                    rsp_full_next  = full_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            len_reg         <= '0;
            idle_reg        <= '0;
            run_task_reg    <= '0;
            run_vr_reg      <= '0;
            run_slice_reg   <= '0;
            tick_reg        <= '0;
            switch_tick_reg <= '0;
            switched_reg    <= 1'b0;
            full_reg        <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            len_reg         <= len_next;
            idle_reg        <= idle_next;
            run_task_reg    <= run_task_next;
            run_vr_reg      <= run_vr_next;
            run_slice_reg   <= run_slice_next;
            tick_reg        <= tick_next;
            switch_tick_reg <= switch_tick_next;
            switched_reg    <= switched_next;
            full_reg        <= full_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        pos_reg      <= pos_next;
        rsp_task_reg <= rsp_task_next;
        rsp_sw_reg   <= rsp_sw_next;
        rsp_cnt_reg  <= rsp_cnt_next;
        rsp_full_reg <= rsp_full_next;
    end

    vts_row u_row (
        .clk      (clk),
        .cmd      (row_cmd),
        .key      (key_reg),
        .idle_id  (idle_reg),
        .head     (head),
        .stop_vec (stop_vec)
    );

    assign req.ready            = (state_reg == S_IDLE);
    assign cfg.ready            = 1'b1;
    assign rsp.valid            = rsp_valid_reg;
    assign rsp.next_task        = FIELD_ID_W'(rsp_task_reg);
    assign rsp.switched         = rsp_sw_reg;
    assign rsp.queued_count     = CNT_FIELD_W'(rsp_cnt_reg);
    assign rsp.queue_full_error = rsp_full_reg;

endmodule

@@ dv/tb.sv @@
// Testbench for the virtual runtime run queue scheduler: a directed table, then random phases.
// Each result is checked against a run queue predictor in this file, or the table value if typed.
// Depends on vts_pkg, the interfaces in vts_ifs and vruntime_timeslice_scheduler_top.
`timescale 1ns / 100ps

module tb;
    import vts_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int DIRECTED_ROWS   = 20;
    localparam int PHASES          = 5;
    localparam int ITEMS_PER_PHASE = 86;
    localparam int PRESSURE_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 80;

    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic [FIELD_ID_W-1:0] task_id;
        logic [VR_W-1:0]       vruntime;
        logic [SLICE_W-1:0]    slice;
        logic                  still_running;
    } sched_req_t;

    typedef struct packed {
        logic [FIELD_ID_W-1:0]  next_task;
        logic                   switched;
        logic [CNT_FIELD_W-1:0] queued_count;
        logic                   queue_full_error;
    } sched_rsp_t;

    typedef struct packed {
        sched_req_t stim;
        logic       typed;
        sched_rsp_t want;
    } dir_row_t;

    typedef enum {MIX_LOAD, FILL_LOAD, DRAIN_LOAD} load_t;

    logic clk = 1'b0;
    logic rst_n;

    vts_req_if req_ch();
    vts_rsp_if rsp_ch();
    vts_cfg_if cfg_ch();

    vruntime_timeslice_scheduler_top dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    vts_entry_t       waiting_tasks[$];
    logic [ID_W-1:0]  run_id      = '0;
    logic [VR_W-1:0]  run_vr      = '0;
    logic [SLICE_W-1:0] run_slice = '0;
    logic [TICK_W-1:0] tick_count = '0;
    logic [TICK_W-1:0] switched_at = '0;
    logic [ID_W-1:0]  idle_id     = '0;

    sched_rsp_t pending_outcomes[$];
    int mismatch_count   = 0;
    int outcomes_checked = 0;
    int burst_left       = 0;
    bit pressure_done    = 1'b0;

    dir_row_t directed_rows [DIRECTED_ROWS] = '{
        '{'{OP_SCHEDULE, 8'h00, 32'd0,        16'd0,     1'b1}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0}},
        '{'{OP_UNUSED,   8'hff, 32'hffffffff, 16'hffff,  1'b1}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0}},
        '{'{OP_ENQUEUE,  8'h11, 32'd100,      16'd2,     1'b0}, 1'b1, '{8'h00, 1'b0, 6'd1, 1'b0}},
        '{'{OP_ENQUEUE,  8'h22, 32'd100,      16'd0,     1'b1}, 1'b0, '0},
        '{'{OP_ENQUEUE,  8'h00, 32'd0,        16'd0,     1'b0}, 1'b0, '0},
        '{'{OP_ENQUEUE,  8'h33, 32'd0,        16'd5,     1'b0}, 1'b0, '0},
        '{'{OP_SCHEDULE, 8'h00, 32'd0,        16'd0,     1'b1}, 1'b0, '0},
        '{'{OP_TICK,     8'h00, 32'd0,        16'd0,     1'b0}, 1'b0, '0},
        '{'{OP_TICK,     8'hff, 32'hffffffff, 16'hffff,  1'b1}, 1'b0, '0},
        '{'{OP_SCHEDULE, 8'h00, 32'd0,        16'd0,     1'b1}, 1'b0, '0},
        '{'{OP_SCHEDULE, 8'h00, 32'd0,        16'd0,     1'b0}, 1'b0, '0},
        '{'{OP_ENQUEUE,  8'hff, 32'hffffffff, 16'd0,     1'b1}, 1'b0, '0},
        '{'{OP_SCHEDULE, 8'h00, 32'd0,        16'd0,     1'b1}, 1'b0, '0},
        '{'{OP_SCHEDULE, 8'h00, 32'd0,        16'd0,     1'b0}, 1'b0, '0},
        '{'{OP_SCHEDULE, 8'h00, 32'd0,        16'd0,     1'b0}, 1'b0, '0},
        '{'{OP_TICK,     8'h00, 32'd0,        16'd0,     1'b0}, 1'b0, '0},
        '{'{OP_SCHEDULE, 8'h00, 32'd0,        16'd0,     1'b1}, 1'b0, '0},
        '{'{OP_ENQUEUE,  8'h80, 32'hffffffff, 16'hffff,  1'b0}, 1'b0, '0},
        '{'{OP_SCHEDULE, 8'h00, 32'd0,        16'd0,     1'b1}, 1'b0, '0},
        '{'{OP_TICK,     8'hff, 32'hffffffff, 16'hffff,  1'b1}, 1'b0, '0}
    };

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic void runqueue_insert(input vts_entry_t e);
        int pos;
        pos = 0;
        if (e.task_id == idle_id)
        begin
            pos = waiting_tasks.size();
        end
        else
        begin
            while (pos < waiting_tasks.size() && waiting_tasks[pos].task_id != idle_id
                   && e.vruntime > waiting_tasks[pos].vruntime)
                pos++;
        end
        waiting_tasks.insert(pos, e);
    endfunction

    function automatic sched_rsp_t predict_outcome(input sched_req_t r);
        sched_rsp_t o;
        logic [TICK_W-1:0] used;
        logic [VR_W:0] charged;
        logic was_idle;
        vts_entry_t head;
        vts_entry_t outgoing;
        o = '0;
        case (r.op)
            OP_TICK:
            begin
                tick_count = tick_count + 1'b1;
            end
            OP_ENQUEUE:
            begin
                if (waiting_tasks.size() >= QUEUE_DEPTH)
                    o.queue_full_error = 1'b1;
                else
                    runqueue_insert('{task_id: r.task_id[ID_W-1:0], vruntime: r.vruntime,
                                      slice: r.slice});
            end
            OP_SCHEDULE:
            begin
                used = tick_count - switched_at;
                was_idle = (run_id == idle_id);
                if ((was_idle || used >= run_slice || !r.still_running)
                    && waiting_tasks.size() > 0)
                begin
                    head = waiting_tasks.pop_front();
                    if (!was_idle)
                    begin
                        charged = {1'b0, run_vr} + used;
                        run_vr = charged[VR_W] ? '1 : charged[VR_W-1:0];
                    end
                    if (r.still_running)
                    begin
                        outgoing = '{task_id: run_id, vruntime: run_vr, slice: run_slice};
                        if (was_idle)
                            waiting_tasks.push_back(outgoing);
                        else
                            runqueue_insert(outgoing);
                    end
                    run_id = head.task_id;
                    run_vr = head.vruntime;
                    run_slice = head.slice;
                    switched_at = tick_count;
                    o.switched = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        o.next_task = FIELD_ID_W'(run_id);
        o.queued_count = CNT_FIELD_W'(waiting_tasks.size());
        return o;
    endfunction

    function automatic sched_req_t draw_request(input load_t load);
        sched_req_t r;
        int pick;
        int enq_cut;
        int tick_cut;
        int sched_cut;
        case (load)
            FILL_LOAD:  begin enq_cut = 70; tick_cut = 80; sched_cut = 97; end
            DRAIN_LOAD: begin enq_cut = 25; tick_cut = 55; sched_cut = 97; end
            default:    begin enq_cut = 40; tick_cut = 65; sched_cut = 95; end
        endcase
        pick = $urandom_range(0, 99);
        if (pick < enq_cut)
            r.op = OP_ENQUEUE;
        else if (pick < tick_cut)
            r.op = OP_TICK;
        else if (pick < sched_cut)
            r.op = OP_SCHEDULE;
        else
            r.op = OP_UNUSED;

        pick = $urandom_range(0, 9);
        if (pick < 2)
            r.task_id = FIELD_ID_W'(idle_id);
        else if (pick < 8)
            r.task_id = FIELD_ID_W'($urandom_range(0, 15));
        else
            r.task_id = FIELD_ID_W'($urandom);

        pick = $urandom_range(0, 99);
        if (pick < 50)
            r.vruntime = VR_W'($urandom_range(0, 63));
        else if (pick < 65)
            r.vruntime = '0;
        else if (pick < 75)
            r.vruntime = '1;
        else
            r.vruntime = VR_W'($urandom);

        pick = $urandom_range(0, 99);
        if (pick < 60)
            r.slice = SLICE_W'($urandom_range(0, 6));
        else if (pick < 70)
            r.slice = '0;
        else if (pick < 80)
            r.slice = '1;
        else
            r.slice = SLICE_W'($urandom);

        if (load == DRAIN_LOAD)
            r.still_running = ($urandom_range(0, 9) < 3);
        else
            r.still_running = ($urandom_range(0, 3) != 0);
        return r;
    endfunction

    task automatic send_request(input sched_req_t r, input logic typed, input sched_rsp_t want);
        int gap;
        sched_rsp_t predicted;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 99) < 15) ? $urandom_range(30, 60)
                                                       : $urandom_range(1, 10);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_ch.op            <= r.op;
        req_ch.task_id       <= r.task_id;
        req_ch.task_vruntime <= r.vruntime;
        req_ch.task_slice    <= r.slice;
        req_ch.still_running <= r.still_running;
        req_ch.valid         <= 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = predict_outcome(r);
        pending_outcomes.push_back(typed ? want : predicted);
    endtask

    task automatic drain_and_set_idle(input logic [FIELD_ID_W-1:0] value);
        req_ch.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        cfg_ch.data  <= value;
        cfg_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        idle_id = value[ID_W-1:0];
    endtask

    always @(posedge clk)
    begin
        sched_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                report_mismatch($sformatf("response with nothing expected, next_task %0h",
                                          rsp_ch.next_task));
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (rsp_ch.next_task !== want.next_task)
                    report_mismatch($sformatf("next_task got %0h expected %0h",
                                              rsp_ch.next_task, want.next_task));
                if (rsp_ch.switched !== want.switched)
                    report_mismatch($sformatf("switched got %0b expected %0b",
                                              rsp_ch.switched, want.switched));
                if (rsp_ch.queued_count !== want.queued_count)
                    report_mismatch($sformatf("queued_count got %0d expected %0d",
                                              rsp_ch.queued_count, want.queued_count));
                if (rsp_ch.queue_full_error !== want.queue_full_error)
                    report_mismatch($sformatf("queue_full_error got %0b expected %0b",
                                              rsp_ch.queue_full_error,
                                              want.queue_full_error));
            end
            outcomes_checked++;
        end
    end

    initial
    begin
        int run;
        int stall;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            run = $urandom_range(0, 9) == 0 ? $urandom_range(40, 80) : $urandom_range(1, 20);
            stall = $urandom_range(0, 4);
            rsp_ch.ready <= 1'b1;
            repeat (run) @(posedge clk);
            if (!pressure_done && outcomes_checked >= 120)
            begin
                stall = PRESSURE_CYCLES;
                pressure_done = 1'b1;
            end
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    initial
    begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        logic [FIELD_ID_W-1:0] phase_idle [PHASES];
        load_t phase_load [PHASES];
        req_ch.valid         = 1'b0;
        req_ch.op            = OP_TICK;
        req_ch.task_id       = '0;
        req_ch.task_vruntime = '0;
        req_ch.task_slice    = '0;
        req_ch.still_running = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.data          = '0;
        rst_n                = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_request(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

        phase_idle = '{8'hff, FIELD_ID_W'($urandom_range(1, 254)), 8'h00, 8'h03,
                       FIELD_ID_W'($urandom_range(0, 15))};
        phase_load = '{MIX_LOAD, MIX_LOAD, FILL_LOAD, DRAIN_LOAD, MIX_LOAD};
        for (int p = 0; p < PHASES; p++)
        begin
            drain_and_set_idle(phase_idle[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_request(draw_request(phase_load[p]), 1'b0, '0);
        end

        req_ch.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ vruntime_timeslice_scheduler_top.f @@
sv/vts_pkg.sv
sv/vts_ifs.sv
sv/vts_cell.sv
sv/vts_row.sv
sv/vruntime_timeslice_scheduler_top.sv
dv/tb.sv
